/* rtl/mbv_pkg.sv */
// Package for the mesh bounding volume block: payload structs, coordinate
// constants and the input saturation function. No dependencies.
package mbv_pkg;

    localparam int COORD_W = 24;
    localparam int RAD_W   = 25;
    localparam int DIFF_W  = 25;
    localparam int MAG_W   = 24;
    localparam int SQ_W    = 48;
    localparam int DIST_W  = 50;
    localparam int SQR_REM_W = 26;
    localparam int VTX_W   = 3 * COORD_W;

    localparam logic signed [COORD_W-1:0] COORD_LIMIT     = 24'sd5120000;
    localparam logic signed [COORD_W-1:0] COORD_LIMIT_NEG = -24'sd5120000;

    typedef logic signed [COORD_W-1:0] coord_t;

    typedef struct packed {
        coord_t coord_x;
        coord_t coord_y;
        coord_t coord_z;
        logic   last_vertex;
    } vertex_t;

    typedef struct packed {
        coord_t             box_min_x;
        coord_t             box_min_y;
        coord_t             box_min_z;
        coord_t             box_max_x;
        coord_t             box_max_y;
        coord_t             box_max_z;
        coord_t             center_x;
        coord_t             center_y;
        coord_t             center_z;
        logic [RAD_W-1:0]   sphere_radius;
    } result_t;

    typedef struct packed {
        coord_t min_x;
        coord_t min_y;
        coord_t min_z;
        coord_t max_x;
        coord_t max_y;
        coord_t max_z;
    } box_t;

    function automatic coord_t sat_coord(input coord_t v);
        coord_t r;
        if (v > COORD_LIMIT) begin
            r = COORD_LIMIT;
        end else if (v < COORD_LIMIT_NEG) begin
            r = COORD_LIMIT_NEG;
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

/* rtl/mesh_bounding_volume.sv */
// Top level of the mesh bounding volume block: front end, vertex RAM, back end.
// Depends on mbv_pkg, mbv_ram, mbv_front and mbv_back.
//
//   channel   direction  handshake          payload
//   s_        in         s_valid / s_ready  mbv_pkg::vertex_t (one vertex)
//   m_        out        m_valid / m_ready  mbv_pkg::result_t (one per mesh)
//
// The front end accepts a vertex while s_ready is high. After the last vertex
// of a mesh the back end runs three serial divisions for the centroid, a
// distance pass over the vertex RAM (N vertices held) and a serial square root.
// s_ready stays low from the last vertex until the distance pass is done.
// Reset is synchronous; no RAM clearing pass is needed.
module mesh_bounding_volume #(
    parameter int MAX_VERTICES = 1024
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  mbv_pkg::vertex_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output mbv_pkg::result_t  m_data
);
    import mbv_pkg::*;

    localparam int CNT_W  = $clog2(MAX_VERTICES + 1);
    localparam int ADDR_W = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int SUM_W  = COORD_W + CNT_W;

    logic                    ram_we;
    logic [ADDR_W-1:0]       ram_waddr, ram_raddr;
    logic [VTX_W-1:0]        ram_wdata, ram_rdata;
    logic                    pass_done;
    logic                    job_valid, job_ready;
    box_t                    job_box;
    logic signed [SUM_W-1:0] job_sum_x, job_sum_y, job_sum_z;
    logic [CNT_W-1:0]        job_count;

    mbv_front #(
        .MAX_VERTICES(MAX_VERTICES), .CNT_W(CNT_W), .SUM_W(SUM_W), .ADDR_W(ADDR_W)
    ) u_front (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .pass_done(pass_done),
        .ram_we(ram_we), .ram_waddr(ram_waddr), .ram_wdata(ram_wdata),
        .job_valid(job_valid), .job_ready(job_ready), .job_box(job_box),
        .job_sum_x(job_sum_x), .job_sum_y(job_sum_y), .job_sum_z(job_sum_z),
        .job_count(job_count)
    );

    mbv_ram #(
        .WIDTH(VTX_W), .DEPTH(MAX_VERTICES), .ADDR_W(ADDR_W)
    ) u_ram (
        .aclk(aclk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
        .raddr(ram_raddr), .rdata(ram_rdata)
    );

    mbv_back #(
        .CNT_W(CNT_W), .SUM_W(SUM_W), .ADDR_W(ADDR_W)
    ) u_back (
        .aclk(aclk), .aresetn(aresetn),
        .job_valid(job_valid), .job_ready(job_ready), .job_box(job_box),
        .job_sum_x(job_sum_x), .job_sum_y(job_sum_y), .job_sum_z(job_sum_z),
        .job_count(job_count),
        .ram_raddr(ram_raddr), .ram_rdata(ram_rdata),
        .pass_done(pass_done),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );
endmodule

/* rtl/mbv_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module mbv_ram #(
    parameter int WIDTH  = 72,
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = 10
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

/* rtl/mbv_front.sv */
// Front end: accepts vertices, saturates, stores them and keeps box, sums and count.
// Hands each finished mesh to the back end through a one-entry job slot. Uses mbv_pkg.
module mbv_front #(
    parameter int MAX_VERTICES = 1024,
    parameter int CNT_W        = 11,
    parameter int SUM_W        = 35,
    parameter int ADDR_W       = 10
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  mbv_pkg::vertex_t         s_data,
    input  logic                     pass_done,
    output logic                     ram_we,
    output logic [ADDR_W-1:0]        ram_waddr,
    output logic [mbv_pkg::VTX_W-1:0] ram_wdata,
    output logic                     job_valid,
    input  logic                     job_ready,
    output mbv_pkg::box_t            job_box,
    output logic signed [SUM_W-1:0]  job_sum_x,
    output logic signed [SUM_W-1:0]  job_sum_y,
    output logic signed [SUM_W-1:0]  job_sum_z,
    output logic [CNT_W-1:0]         job_count
);
    import mbv_pkg::*;

    logic                    hold_reg;
    logic                    job_valid_reg;
    logic [CNT_W-1:0]        count_reg, count_next;
    logic signed [SUM_W-1:0] sx_reg, sy_reg, sz_reg;
    logic signed [SUM_W-1:0] sx_next, sy_next, sz_next;
    box_t                    box_reg, box_next;
    coord_t                  x, y, z;
    logic                    accept, store;

    assign s_ready   = !hold_reg;
    assign accept    = s_valid && s_ready;
    assign x         = sat_coord(s_data.coord_x);
    assign y         = sat_coord(s_data.coord_y);
    assign z         = sat_coord(s_data.coord_z);
    assign store     = accept && (count_reg < CNT_W'(MAX_VERTICES));
    assign ram_we    = store;
    assign ram_waddr = count_reg[ADDR_W-1:0];
    assign ram_wdata = {x, y, z};
    assign job_valid = job_valid_reg;

    always_comb begin
        count_next = count_reg;
        sx_next    = sx_reg;
        sy_next    = sy_reg;
        sz_next    = sz_reg;
        box_next   = box_reg;
        if (store) begin
            count_next = count_reg + 1'b1;
            sx_next    = sx_reg + SUM_W'(x);
            sy_next    = sy_reg + SUM_W'(y);
            sz_next    = sz_reg + SUM_W'(z);
            if (x < box_reg.min_x) box_next.min_x = x;
            if (y < box_reg.min_y) box_next.min_y = y;
            if (z < box_reg.min_z) box_next.min_z = z;
            if (x > box_reg.max_x) box_next.max_x = x;
            if (y > box_reg.max_y) box_next.max_y = y;
            if (z > box_reg.max_z) box_next.max_z = z;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_reg      <= 1'b0;
            job_valid_reg <= 1'b0;
            count_reg     <= '0;
            sx_reg        <= '0;
            sy_reg        <= '0;
            sz_reg        <= '0;
            box_reg       <= '{COORD_LIMIT, COORD_LIMIT, COORD_LIMIT,
                               COORD_LIMIT_NEG, COORD_LIMIT_NEG, COORD_LIMIT_NEG};
        end else begin
            if (job_valid_reg && job_ready) begin
                job_valid_reg <= 1'b0;
            end
            if (pass_done) begin
                hold_reg <= 1'b0;
            end
            if (accept && s_data.last_vertex) begin
                job_box       <= box_next;
                job_sum_x     <= sx_next;
                job_sum_y     <= sy_next;
                job_sum_z     <= sz_next;
                job_count     <= count_next;
                job_valid_reg <= 1'b1;
                hold_reg      <= 1'b1;
                count_reg     <= '0;
                sx_reg        <= '0;
                sy_reg        <= '0;
                sz_reg        <= '0;
                box_reg       <= '{COORD_LIMIT, COORD_LIMIT, COORD_LIMIT,
                                   COORD_LIMIT_NEG, COORD_LIMIT_NEG, COORD_LIMIT_NEG};
            end else begin
                count_reg <= count_next;
                sx_reg    <= sx_next;
                sy_reg    <= sy_next;
                sz_reg    <= sz_next;
                box_reg   <= box_next;
            end
        end
    end
endmodule

/* rtl/mbv_back.sv */
// Back end: centroid by a shared serial divider, distance pass over the vertex RAM,
// serial floor square root, and the result register. Uses mbv_pkg.
module mbv_back #(
    parameter int CNT_W  = 11,
    parameter int SUM_W  = 35,
    parameter int ADDR_W = 10
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      job_valid,
    output logic                      job_ready,
    input  mbv_pkg::box_t             job_box,
    input  logic signed [SUM_W-1:0]   job_sum_x,
    input  logic signed [SUM_W-1:0]   job_sum_y,
    input  logic signed [SUM_W-1:0]   job_sum_z,
    input  logic [CNT_W-1:0]          job_count,
    output logic [ADDR_W-1:0]         ram_raddr,
    input  logic [mbv_pkg::VTX_W-1:0] ram_rdata,
    output logic                      pass_done,
    output logic                      m_valid,
    input  logic                      m_ready,
    output mbv_pkg::result_t          m_data
);
    import mbv_pkg::*;

    localparam int STEP_W = $clog2(SUM_W + RAD_W + 1);
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_DIV  = 3'd1;
    localparam logic [2:0] ST_PASS = 3'd2;
    localparam logic [2:0] ST_SQRT = 3'd3;
    localparam logic [2:0] ST_OUT  = 3'd4;

    logic [2:0]              state_reg;
    box_t                    box_reg;
    logic [CNT_W-1:0]        cnt_reg;
    logic signed [SUM_W-1:0] sum_reg [3];
    coord_t                  center_reg [3];
    logic [1:0]              axis_reg, axis_inc;
    logic [STEP_W-1:0]       step_reg;
    logic [CNT_W:0]          rem_reg, rem_sh;
    logic [SUM_W-1:0]        quo_reg, quo_fin;
    logic                    neg_reg, div_ge;
    logic signed [SUM_W-1:0] sum_sel;

    logic [CNT_W-1:0]        rd_idx_reg;
    logic                    issue;
    logic                    v1_reg, v2_reg, v3_reg, v4_reg;
    logic signed [DIFF_W-1:0] diff_reg [3];
    logic [MAG_W-1:0]        mag_reg [3];
    logic [SQ_W-1:0]         sq_reg [3];
    logic [DIST_W-1:0]       best_reg, dist_sum;
    coord_t                  rd_coord [3];

    logic [DIST_W-1:0]       src_reg;
    logic [SQR_REM_W-1:0]    sqr_rem_reg;
    logic [RAD_W-1:0]        root_reg;
    logic [SQR_REM_W+1:0]    sqr_sh, sqr_trial;
    logic                    sqr_ge;

    logic                    m_valid_reg;
    result_t                 m_data_reg;

    assign job_ready = (state_reg == ST_IDLE);
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    assign axis_inc = axis_reg + 2'd1;
    assign sum_sel  = sum_reg[axis_inc];
    assign rem_sh   = {rem_reg[CNT_W-1:0], quo_reg[SUM_W-1]};
    assign div_ge   = rem_sh >= {1'b0, cnt_reg};
    assign quo_fin  = {quo_reg[SUM_W-2:0], div_ge};

    assign issue     = (state_reg == ST_PASS) && (rd_idx_reg < cnt_reg);
    assign ram_raddr = rd_idx_reg[ADDR_W-1:0];
    assign pass_done = (state_reg == ST_PASS) && !issue
                       && !v1_reg && !v2_reg && !v3_reg && !v4_reg;
    assign rd_coord[0] = ram_rdata[3*COORD_W-1:2*COORD_W];
    assign rd_coord[1] = ram_rdata[2*COORD_W-1:COORD_W];
    assign rd_coord[2] = ram_rdata[COORD_W-1:0];
    assign dist_sum = DIST_W'(sq_reg[0]) + DIST_W'(sq_reg[1]) + DIST_W'(sq_reg[2]);

    assign sqr_sh    = {sqr_rem_reg, src_reg[DIST_W-1:DIST_W-2]};
    assign sqr_trial = (SQR_REM_W+2)'({root_reg, 2'b01});
    assign sqr_ge    = sqr_sh >= sqr_trial;

    always_ff @(posedge aclk) begin
        for (int i = 0; i < 3; i++) begin
            diff_reg[i] <= DIFF_W'(rd_coord[i]) - DIFF_W'(center_reg[i]);
            mag_reg[i]  <= diff_reg[i][DIFF_W-1] ? MAG_W'(-diff_reg[i])
                                                 : MAG_W'(diff_reg[i]);
            sq_reg[i]   <= mag_reg[i] * mag_reg[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            v4_reg      <= 1'b0;
        end else begin
            v1_reg <= issue;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (job_valid) begin
                        box_reg    <= job_box;
                        cnt_reg    <= job_count;
                        sum_reg[0] <= job_sum_x;
                        sum_reg[1] <= job_sum_y;
                        sum_reg[2] <= job_sum_z;
                        axis_reg   <= 2'd0;
                        step_reg   <= '0;
                        rem_reg    <= '0;
                        neg_reg    <= job_sum_x[SUM_W-1];
                        quo_reg    <= job_sum_x[SUM_W-1] ? SUM_W'(-job_sum_x)
                                                         : SUM_W'(job_sum_x);
                        state_reg  <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    rem_reg  <= div_ge ? rem_sh - {1'b0, cnt_reg} : rem_sh;
                    quo_reg  <= quo_fin;
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == STEP_W'(SUM_W - 1)) begin
                        center_reg[axis_reg] <= neg_reg ? -COORD_W'(quo_fin)
                                                        : COORD_W'(quo_fin);
                        step_reg <= '0;
                        rem_reg  <= '0;
                        if (axis_reg == 2'd2) begin
                            rd_idx_reg <= '0;
                            best_reg   <= '0;
                            state_reg  <= ST_PASS;
                        end else begin
                            axis_reg <= axis_inc;
                            neg_reg  <= sum_sel[SUM_W-1];
                            quo_reg  <= sum_sel[SUM_W-1] ? SUM_W'(-sum_sel)
                                                         : SUM_W'(sum_sel);
                        end
                    end
                end
                ST_PASS: begin
                    if (issue) begin
                        rd_idx_reg <= rd_idx_reg + 1'b1;
                    end
                    if (v4_reg && dist_sum > best_reg) begin
                        best_reg <= dist_sum;
                    end
                    if (pass_done) begin
                        src_reg     <= best_reg;
                        sqr_rem_reg <= '0;
                        root_reg    <= '0;
                        step_reg    <= '0;
                        state_reg   <= ST_SQRT;
                    end
                end
                ST_SQRT: begin
                    sqr_rem_reg <= sqr_ge ? SQR_REM_W'(sqr_sh - sqr_trial)
                                          : SQR_REM_W'(sqr_sh);
                    root_reg    <= {root_reg[RAD_W-2:0], sqr_ge};
                    src_reg     <= {src_reg[DIST_W-3:0], 2'b00};
                    step_reg    <= step_reg + 1'b1;
                    if (step_reg == STEP_W'(RAD_W - 1)) begin
                        state_reg <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (!m_valid_reg || m_ready) begin
                        m_data_reg.box_min_x     <= box_reg.min_x;
                        m_data_reg.box_min_y     <= box_reg.min_y;
                        m_data_reg.box_min_z     <= box_reg.min_z;
                        m_data_reg.box_max_x     <= box_reg.max_x;
                        m_data_reg.box_max_y     <= box_reg.max_y;
                        m_data_reg.box_max_z     <= box_reg.max_z;
                        m_data_reg.center_x      <= center_reg[0];
                        m_data_reg.center_y      <= center_reg[1];
                        m_data_reg.center_z      <= center_reg[2];
                        m_data_reg.sphere_radius <= root_reg;
                        m_valid_reg              <= 1'b1;
                        state_reg                <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end
endmodule
